// ===== rtl/core/uads_pkg.sv =====
package uads_pkg;

	localparam int MAX_COLS  = 256;
	localparam int MAX_ROWS  = 256;
	localparam int FRAC_BITS = 24;

	localparam int ROW_STORES = 3;
	localparam int MEM_DEPTH  = ROW_STORES * MAX_COLS;
	localparam int MEM_AW     = $clog2(MEM_DEPTH);
	localparam int DIM_W      = 9;
	localparam int IDX_W      = 8;
	localparam int VAL_W      = 32;
	localparam int GAIN_W     = 31;
	localparam int CFG_IDX_W  = 3;

	localparam int MA_W   = 62;
	localparam int MB_W   = 34;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SAT_SH = 60;
	localparam int ACC_W  = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_ROW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_COL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ADV_ROW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ADV_COL   = 3'd5;

	localparam logic [DIM_W-1:0]  RST_GRID_ROWS = 9'd51;
	localparam logic [DIM_W-1:0]  RST_GRID_COLS = 9'd51;
	localparam logic [GAIN_W-1:0] RST_DIFF_GAIN = 31'd838861;
	localparam logic [GAIN_W-1:0] RST_ADV_GAIN  = 31'd167772;

	localparam logic [1:0] SEL_DIAG = 2'd0;
	localparam logic [1:0] SEL_EDGE = 2'd1;
	localparam logic [1:0] SEL_SELF = 2'd2;

	localparam logic [2:0] NB_C = 3'd0;
	localparam logic [2:0] NB_N = 3'd1;
	localparam logic [2:0] NB_S = 3'd2;
	localparam logic [2:0] NB_W = 3'd3;
	localparam logic [2:0] NB_E = 3'd4;

	localparam logic [3:0] OP_U_DR   = 4'd0;
	localparam logic [3:0] OP_U_DC   = 4'd1;
	localparam logic [3:0] OP_U_VR   = 4'd2;
	localparam logic [3:0] OP_U_AR   = 4'd3;
	localparam logic [3:0] OP_U_VC   = 4'd4;
	localparam logic [3:0] OP_U_AC   = 4'd5;
	localparam logic [3:0] OP_V_DR   = 4'd6;
	localparam logic [3:0] OP_V_DC   = 4'd7;
	localparam logic [3:0] OP_V_VR   = 4'd8;
	localparam logic [3:0] OP_V_AR   = 4'd9;
	localparam logic [3:0] OP_V_VC   = 4'd10;
	localparam logic [3:0] OP_V_AC   = 4'd11;

	typedef struct packed {
		logic signed [VAL_W-1:0] u_old;
		logic signed [VAL_W-1:0] v_old;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        cell_row;
		logic [IDX_W-1:0]        cell_col;
		logic signed [VAL_W-1:0] u_new;
		logic signed [VAL_W-1:0] v_new;
		logic                    run_last;
		logic                    frame_done;
	} out_item_t;

	typedef struct packed {
		logic       accept;
		logic       pick;
		logic [1:0] sel;
		logic       rd;
		logic [2:0] rd_idx;
		logic       mul_start;
		logic [3:0] op;
		logic       load;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [2:0] emit;
		logic       interior;
		logic       mul_done;
		logic       out_free;
	} status_t;

endpackage

// ===== rtl/core/uads_ram.sv =====
module uads_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/uads_mul.sv =====
module uads_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [uads_pkg::MA_W-1:0]    a,
	input  logic signed [uads_pkg::MB_W-1:0]    b,
	output logic                                done,
	output logic signed [uads_pkg::MA_W-1:0]    q
);

	localparam int CNT_W = $clog2(uads_pkg::MB_W);

	logic [uads_pkg::MA_W-1:0]   ma_q;
	logic [uads_pkg::MA_W-1:0]   hi_q;
	logic [uads_pkg::MB_W-1:0]   lo_q;
	logic                        neg_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        fin_q;
	logic                        done_q;
	logic signed [uads_pkg::MA_W-1:0] q_q;

	logic [uads_pkg::MA_W:0]                     sum;
	logic [uads_pkg::PROD_W-1:0]                 prod;
	logic [uads_pkg::PROD_W-uads_pkg::FRAC_BITS-1:0] q0;
	logic                                        rem;
	logic [uads_pkg::MA_W-1:0]                   qm;

	always_comb begin
		sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, ma_q} : '0);
		prod = {hi_q, lo_q};
		q0   = prod[uads_pkg::PROD_W-1:uads_pkg::FRAC_BITS];
		rem  = |prod[uads_pkg::FRAC_BITS-1:0];
		if (q0 >= ((uads_pkg::PROD_W-uads_pkg::FRAC_BITS)'(1) << uads_pkg::SAT_SH)) begin
			qm = uads_pkg::MA_W'(1) << uads_pkg::SAT_SH;
		end else begin
			qm = q0[uads_pkg::MA_W-1:0] + uads_pkg::MA_W'(neg_q && rem);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(uads_pkg::MB_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[uads_pkg::MA_W-1] ? uads_pkg::MA_W'(-a) : uads_pkg::MA_W'(a);
			lo_q  <= b[uads_pkg::MB_W-1] ? uads_pkg::MB_W'(-b) : uads_pkg::MB_W'(b);
			neg_q <= a[uads_pkg::MA_W-1] ^ b[uads_pkg::MB_W-1];
			hi_q  <= '0;
		end else if (busy_q) begin
			hi_q <= sum[uads_pkg::MA_W:1];
			lo_q <= {sum[0], lo_q[uads_pkg::MB_W-1:1]};
		end
		if (fin_q) begin
			q_q <= neg_q ? -$signed(qm) : $signed(qm);
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

// ===== rtl/core/uads_ctrl.sv =====
module uads_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  uads_pkg::status_t status,
	output uads_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_NEXT   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_WAIT   = 3'd3;
	localparam logic [2:0] ST_MSTART = 3'd4;
	localparam logic [2:0] ST_MWAIT  = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] pend_q;
	logic [2:0] rd_k_q;
	logic [3:0] op_q;
	logic       last_q;
	logic [1:0] sel;
	logic [2:0] pend_rest;

	always_comb begin
		if (pend_q[0]) begin
			sel       = uads_pkg::SEL_DIAG;
			pend_rest = pend_q & 3'b110;
		end else if (pend_q[1]) begin
			sel       = uads_pkg::SEL_EDGE;
			pend_rest = pend_q & 3'b100;
		end else begin
			sel       = uads_pkg::SEL_SELF;
			pend_rest = 3'b000;
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.sel  = sel;
		cmd.rd_idx = rd_k_q;
		cmd.op   = op_q;
		cmd.last = last_q;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (pend_q == 3'b000) begin
					state_d = ST_IDLE;
				end else begin
					cmd.pick = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				if (rd_k_q == uads_pkg::NB_E) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = status.interior ? ST_MSTART : ST_OUT;
			end
			ST_MSTART: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (status.mul_done) begin
					state_d = (op_q == uads_pkg::OP_V_AC) ? ST_OUT : ST_MSTART;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_NEXT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= '0;
			rd_k_q  <= '0;
			op_q    <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				pend_q <= status.emit;
			end
			if (cmd.pick) begin
				pend_q <= pend_rest;
				last_q <= (pend_rest == 3'b000);
				rd_k_q <= uads_pkg::NB_C;
			end
			if (cmd.rd) begin
				rd_k_q <= rd_k_q + 1'b1;
			end
			if (state_q == ST_WAIT) begin
				op_q <= uads_pkg::OP_U_DR;
			end
			if (state_q == ST_MWAIT && status.mul_done && op_q != uads_pkg::OP_V_AC) begin
				op_q <= op_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/uads_dp.sv =====
module uads_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [uads_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [uads_pkg::GAIN_W-1:0]         cfg_wdata,
	input  uads_pkg::in_item_t                  in_data,
	input  uads_pkg::cmd_t                      cmd,
	output uads_pkg::status_t                   status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output uads_pkg::out_item_t                 out_data
);

	localparam int DW = uads_pkg::DIM_W;
	localparam int IW = uads_pkg::IDX_W;
	localparam int VW = uads_pkg::VAL_W;
	localparam int AW = uads_pkg::MEM_AW;

	function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v, input int maxp);
		logic [DW-1:0] hi;
		hi = DW'((maxp < 256) ? maxp : 256);
		if (v < DW'(3)) begin
			return DW'(3);
		end
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [1:0] m3_prev(input logic [1:0] m);
		return (m == 2'd0) ? 2'd2 : m - 2'd1;
	endfunction

	function automatic logic [1:0] m3_next(input logic [1:0] m);
		return (m == 2'd2) ? 2'd0 : m + 2'd1;
	endfunction

	function automatic logic [AW-1:0] slot(input logic [1:0] m, input logic [IW-1:0] c);
		return AW'(m) * AW'(uads_pkg::MAX_COLS) + AW'(c);
	endfunction

	function automatic logic signed [VW-1:0] sat32(input logic signed [uads_pkg::ACC_W-1:0] s);
		if (s > uads_pkg::ACC_W'(signed'(32'sh7fffffff))) begin
			return 32'sh7fffffff;
		end
		if (s < uads_pkg::ACC_W'(signed'(32'sh80000000))) begin
			return 32'sh80000000;
		end
		return s[VW-1:0];
	endfunction

	logic [DW-1:0]                rows_q, cols_q;
	logic [uads_pkg::GAIN_W-1:0]  dr_q, dc_q, ar_q, ac_q;
	logic [DW-1:0]                rows_eff, cols_eff;

	logic [IW-1:0] in_row_q, in_col_q;
	logic [1:0]    in_m3_q;
	logic          row_end, last_row;

	logic [IW-1:0] i_q, j_q;
	logic [1:0]    m3_q;
	logic          row_end_q;

	logic [IW-1:0] cell_r_q, cell_c_q;
	logic [1:0]    cell_m_q;
	logic          fdone_q;

	logic [AW-1:0] waddr, raddr;
	logic [VW-1:0] u_rdata, v_rdata;
	logic          rd_v_s1;
	logic [2:0]    rd_idx_s1;

	logic signed [VW-1:0] uc_q, un_q, us_q, uw_q, ue_q;
	logic signed [VW-1:0] vc_q, vn_q, vs_q, vw_q, ve_q;

	logic signed [uads_pkg::ACC_W-1:0] acc_u_q, acc_v_q;
	logic signed [uads_pkg::MA_W-1:0]  tmp_q;
	logic [3:0]                        op_q;

	logic signed [33:0] lap_ur, lap_uc, lap_vr, lap_vc;
	logic signed [32:0] du_r, dv_r, du_c, dv_c;
	logic signed [uads_pkg::MA_W-1:0] mul_a, mul_q;
	logic signed [uads_pkg::MB_W-1:0] mul_b;
	logic                             mul_done;
	logic                             out_valid_q;
	uads_pkg::out_item_t              out_q;

	assign rows_eff = clamp_dim(rows_q, uads_pkg::MAX_ROWS);
	assign cols_eff = clamp_dim(cols_q, uads_pkg::MAX_COLS);
	assign row_end  = ({1'b0, in_col_q} + DW'(1)) >= cols_eff;
	assign last_row = ({1'b0, in_row_q} + DW'(1)) >= rows_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= uads_pkg::RST_GRID_ROWS;
			cols_q <= uads_pkg::RST_GRID_COLS;
			dr_q   <= uads_pkg::RST_DIFF_GAIN;
			dc_q   <= uads_pkg::RST_DIFF_GAIN;
			ar_q   <= uads_pkg::RST_ADV_GAIN;
			ac_q   <= uads_pkg::RST_ADV_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				uads_pkg::CFG_GRID_ROWS: rows_q <= cfg_wdata[DW-1:0];
				uads_pkg::CFG_GRID_COLS: cols_q <= cfg_wdata[DW-1:0];
				uads_pkg::CFG_DIFF_ROW:  dr_q   <= cfg_wdata;
				uads_pkg::CFG_DIFF_COL:  dc_q   <= cfg_wdata;
				uads_pkg::CFG_ADV_ROW:   ar_q   <= cfg_wdata;
				uads_pkg::CFG_ADV_COL:   ac_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
			in_m3_q  <= '0;
			rd_v_s1  <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.rd;
			if (cmd.accept) begin
				if (row_end) begin
					in_col_q <= '0;
					in_row_q <= last_row ? '0 : in_row_q + 1'b1;
					in_m3_q  <= last_row ? 2'd0 : m3_next(in_m3_q);
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			i_q       <= in_row_q;
			j_q       <= in_col_q;
			m3_q      <= in_m3_q;
			row_end_q <= row_end;
		end
		if (cmd.pick) begin
			unique case (cmd.sel)
				uads_pkg::SEL_DIAG: begin
					cell_r_q <= i_q - 1'b1;
					cell_c_q <= j_q - 1'b1;
					cell_m_q <= m3_prev(m3_q);
					fdone_q  <= 1'b0;
				end
				uads_pkg::SEL_EDGE: begin
					cell_r_q <= i_q - 1'b1;
					cell_c_q <= j_q;
					cell_m_q <= m3_prev(m3_q);
					fdone_q  <= 1'b0;
				end
				default: begin
					cell_r_q <= i_q;
					cell_c_q <= j_q;
					cell_m_q <= m3_q;
					fdone_q  <= row_end_q;
				end
			endcase
		end
	end

	assign waddr = slot(in_m3_q, in_col_q);

	always_comb begin
		unique case (cmd.rd_idx)
			uads_pkg::NB_N: raddr = slot(m3_prev(cell_m_q), cell_c_q);
			uads_pkg::NB_S: raddr = slot(m3_next(cell_m_q), cell_c_q);
			uads_pkg::NB_W: raddr = slot(cell_m_q, cell_c_q - 1'b1);
			uads_pkg::NB_E: raddr = slot(cell_m_q, cell_c_q + 1'b1);
			default:        raddr = slot(cell_m_q, cell_c_q);
		endcase
	end

	uads_ram #(.WIDTH(VW), .DEPTH(uads_pkg::MEM_DEPTH)) u_ram_u (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (waddr),
		.wdata (in_data.u_old),
		.raddr (raddr),
		.rdata (u_rdata)
	);

	uads_ram #(.WIDTH(VW), .DEPTH(uads_pkg::MEM_DEPTH)) u_ram_v (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (waddr),
		.wdata (in_data.v_old),
		.raddr (raddr),
		.rdata (v_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_idx_s1 <= cmd.rd_idx;
		end
	end

	always_comb begin
		lap_ur = 34'(un_q) + 34'(us_q) - (34'(uc_q) <<< 1);
		lap_uc = 34'(uw_q) + 34'(ue_q) - (34'(uc_q) <<< 1);
		lap_vr = 34'(vn_q) + 34'(vs_q) - (34'(vc_q) <<< 1);
		lap_vc = 34'(vw_q) + 34'(ve_q) - (34'(vc_q) <<< 1);
		if (uc_q > 32'sd0) begin
			du_r = 33'(uc_q) - 33'(un_q);
			dv_r = 33'(vc_q) - 33'(vn_q);
		end else begin
			du_r = 33'(us_q) - 33'(uc_q);
			dv_r = 33'(vs_q) - 33'(vc_q);
		end
		if (vc_q > 32'sd0) begin
			du_c = 33'(uc_q) - 33'(uw_q);
			dv_c = 33'(vc_q) - 33'(vw_q);
		end else begin
			du_c = 33'(ue_q) - 33'(uc_q);
			dv_c = 33'(ve_q) - 33'(vc_q);
		end
	end

	always_comb begin
		case (cmd.op)
			uads_pkg::OP_U_DR: begin mul_a = 62'(lap_ur); mul_b = 34'(dr_q); end
			uads_pkg::OP_U_DC: begin mul_a = 62'(lap_uc); mul_b = 34'(dc_q); end
			uads_pkg::OP_U_VR: begin mul_a = 62'(uc_q);   mul_b = 34'(du_r); end
			uads_pkg::OP_U_AR: begin mul_a = tmp_q;       mul_b = 34'(ar_q); end
			uads_pkg::OP_U_VC: begin mul_a = 62'(vc_q);   mul_b = 34'(du_c); end
			uads_pkg::OP_U_AC: begin mul_a = tmp_q;       mul_b = 34'(ac_q); end
			uads_pkg::OP_V_DR: begin mul_a = 62'(lap_vr); mul_b = 34'(dr_q); end
			uads_pkg::OP_V_DC: begin mul_a = 62'(lap_vc); mul_b = 34'(dc_q); end
			uads_pkg::OP_V_VR: begin mul_a = 62'(uc_q);   mul_b = 34'(dv_r); end
			uads_pkg::OP_V_AR: begin mul_a = tmp_q;       mul_b = 34'(ar_q); end
			uads_pkg::OP_V_VC: begin mul_a = 62'(vc_q);   mul_b = 34'(dv_c); end
			default:           begin mul_a = tmp_q;       mul_b = 34'(ac_q); end
		endcase
	end

	uads_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.q      (mul_q)
	);

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			unique case (rd_idx_s1)
				uads_pkg::NB_C: begin
					uc_q    <= u_rdata;
					vc_q    <= v_rdata;
					acc_u_q <= uads_pkg::ACC_W'(signed'(u_rdata));
					acc_v_q <= uads_pkg::ACC_W'(signed'(v_rdata));
				end
				uads_pkg::NB_N: begin un_q <= u_rdata; vn_q <= v_rdata; end
				uads_pkg::NB_S: begin us_q <= u_rdata; vs_q <= v_rdata; end
				uads_pkg::NB_W: begin uw_q <= u_rdata; vw_q <= v_rdata; end
				default:        begin ue_q <= u_rdata; ve_q <= v_rdata; end
			endcase
		end
		if (cmd.mul_start) begin
			op_q <= cmd.op;
		end
		if (mul_done) begin
			case (op_q)
				uads_pkg::OP_U_DR, uads_pkg::OP_U_DC:
					acc_u_q <= acc_u_q + uads_pkg::ACC_W'(mul_q);
				uads_pkg::OP_U_AR, uads_pkg::OP_U_AC:
					acc_u_q <= acc_u_q - uads_pkg::ACC_W'(mul_q);
				uads_pkg::OP_V_DR, uads_pkg::OP_V_DC:
					acc_v_q <= acc_v_q + uads_pkg::ACC_W'(mul_q);
				uads_pkg::OP_V_AR, uads_pkg::OP_V_AC:
					acc_v_q <= acc_v_q - uads_pkg::ACC_W'(mul_q);
				default:
					tmp_q <= mul_q;
			endcase
		end
	end

	assign status.emit[0]  = (in_row_q != '0) && (in_col_q != '0);
	assign status.emit[1]  = (in_row_q != '0) && row_end;
	assign status.emit[2]  = last_row;
	assign status.interior = (cell_r_q != '0) && (({1'b0, cell_r_q} + DW'(2)) <= rows_eff)
		&& (cell_c_q != '0) && (({1'b0, cell_c_q} + DW'(2)) <= cols_eff);
	assign status.mul_done = mul_done;
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.cell_row   <= cell_r_q;
			out_q.cell_col   <= cell_c_q;
			out_q.u_new      <= status.interior ? sat32(acc_u_q) : uc_q;
			out_q.v_new      <= status.interior ? sat32(acc_v_q) : vc_q;
			out_q.run_last   <= cmd.last;
			out_q.frame_done <= fdone_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/upwind_advection_diffusion_stencil.sv =====
// Per item: an input item that causes no result is only written to the row stores; each
// boundary result takes five row-store reads, each interior result also twelve serial
// multiplies (34 shift-add steps each) on one shared unit.
// Throughput: one input item at a time; up to three results per item, in order.
// Reset: counters clear, configuration registers take their default values; row stores are not cleared.
module upwind_advection_diffusion_stencil (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  uads_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output uads_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [uads_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [uads_pkg::GAIN_W-1:0]     cfg_wdata
);

	uads_pkg::cmd_t    cmd;
	uads_pkg::status_t status;

	uads_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	uads_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	a_frame_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> out_data.run_last)
		else $error("frame end not marked as last result");

	a_frame_done_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> out_data.cell_row != '0)
		else $error("frame end on first row");

endmodule

// ===== tb/sv/upwind_advection_diffusion_stencil_chk.sv =====
module upwind_advection_diffusion_stencil_chk
	import uads_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [GAIN_W-1:0]    cfg_wdata,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [VAL_W-1:0] u_store [0:MEM_DEPTH-1];
	logic signed [VAL_W-1:0] v_store [0:MEM_DEPTH-1];
	int unsigned row_cnt, col_cnt;
	logic [DIM_W-1:0] rows_reg, cols_reg;
	logic [GAIN_W-1:0] dr_gain, dc_gain, ar_gain, ac_gain;
	out_item_t cell_q[$];

	function automatic int unsigned clamp_dim(logic [DIM_W-1:0] d);
		if (d < 3) return 3;
		if (d > 256) return 256;
		return d;
	endfunction

	function automatic int slot_of(int unsigned r, int unsigned c);
		return (r % 3) * MAX_COLS + ((c < MAX_COLS) ? c : MAX_COLS - 1);
	endfunction

	function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [127:0] p;
		p = a * b;
		p = p >>> FRAC_BITS;
		if (p > 128'sd1152921504606846976) p = 128'sd1152921504606846976;
		if (p < -128'sd1152921504606846976) p = -128'sd1152921504606846976;
		return p[63:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_word(logic signed [63:0] s);
		if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (s < -64'sd2147483648) return 32'sh80000000;
		return s[VAL_W-1:0];
	endfunction

	function automatic logic signed [63:0] gain64(logic [GAIN_W-1:0] g);
		return $signed({33'd0, g});
	endfunction

	function automatic out_item_t stencil_cell(int unsigned r, int unsigned c,
			int unsigned nr, int unsigned nc);
		out_item_t o;
		logic signed [63:0] uc, vc, un, us, uw, ue, vn, vs, vw, ve;
		logic signed [63:0] dur, dvr, duc, dvc, su, sv;
		o = '0;
		o.cell_row = r[IDX_W-1:0];
		o.cell_col = c[IDX_W-1:0];
		uc = u_store[slot_of(r, c)];
		vc = v_store[slot_of(r, c)];
		o.u_new = uc[VAL_W-1:0];
		o.v_new = vc[VAL_W-1:0];
		if (r >= 1 && r + 2 <= nr && c >= 1 && c + 2 <= nc) begin
			un = u_store[slot_of(r - 1, c)];
			us = u_store[slot_of(r + 1, c)];
			uw = u_store[slot_of(r, c - 1)];
			ue = u_store[slot_of(r, c + 1)];
			vn = v_store[slot_of(r - 1, c)];
			vs = v_store[slot_of(r + 1, c)];
			vw = v_store[slot_of(r, c - 1)];
			ve = v_store[slot_of(r, c + 1)];
			if (uc > 0) begin
				dur = uc - un;
				dvr = vc - vn;
			end else begin
				dur = us - uc;
				dvr = vs - vc;
			end
			if (vc > 0) begin
				duc = uc - uw;
				dvc = vc - vw;
			end else begin
				duc = ue - uc;
				dvc = ve - vc;
			end
			su = uc + fx_mul(un + us - 2 * uc, gain64(dr_gain))
				+ fx_mul(uw + ue - 2 * uc, gain64(dc_gain))
				- fx_mul(fx_mul(uc, dur), gain64(ar_gain))
				- fx_mul(fx_mul(vc, duc), gain64(ac_gain));
			sv = vc + fx_mul(vn + vs - 2 * vc, gain64(dr_gain))
				+ fx_mul(vw + ve - 2 * vc, gain64(dc_gain))
				- fx_mul(fx_mul(uc, dvr), gain64(ar_gain))
				- fx_mul(fx_mul(vc, dvc), gain64(ac_gain));
			o.u_new = sat_word(su);
			o.v_new = sat_word(sv);
		end
		return o;
	endfunction

	task automatic predict_item(in_item_t it);
		int unsigned nr, nc, i, j;
		bit row_end, last_row;
		out_item_t o;
		int n0;
		nr = clamp_dim(rows_reg);
		nc = clamp_dim(cols_reg);
		i = row_cnt;
		j = col_cnt;
		row_end = (j + 1 >= nc);
		last_row = (i + 1 >= nr);
		n0 = cell_q.size();
		u_store[slot_of(i, j)] = it.u_old;
		v_store[slot_of(i, j)] = it.v_old;
		if (i >= 1 && j >= 1) cell_q.push_back(stencil_cell(i - 1, j - 1, nr, nc));
		if (i >= 1 && row_end) cell_q.push_back(stencil_cell(i - 1, j, nr, nc));
		if (last_row) begin
			o = stencil_cell(i, j, nr, nc);
			o.frame_done = row_end;
			cell_q.push_back(o);
		end
		if (cell_q.size() > n0) cell_q[cell_q.size() - 1].run_last = 1'b1;
		if (row_end) begin
			col_cnt = 0;
			row_cnt = last_row ? 0 : ((i + 1) & 8'hFF);
		end else begin
			col_cnt = (j + 1) & 8'hFF;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_cell;
		if (!arst_n) begin
			row_cnt = 0;
			col_cnt = 0;
			rows_reg = RST_GRID_ROWS;
			cols_reg = RST_GRID_COLS;
			dr_gain = RST_DIFF_GAIN;
			dc_gain = RST_DIFF_GAIN;
			ar_gain = RST_ADV_GAIN;
			ac_gain = RST_ADV_GAIN;
			cell_q.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cell_q.size() == 0) begin
					$display("%0t: unexpected cell, expected none, actual %p", $time, out_data);
					errors++;
				end else begin
					exp_cell = cell_q.pop_front();
					if (out_data !== exp_cell) begin
						$display("%0t: cell mismatch, expected %p, actual %p",
							$time, exp_cell, out_data);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					CFG_GRID_ROWS: rows_reg = cfg_wdata[DIM_W-1:0];
					CFG_GRID_COLS: cols_reg = cfg_wdata[DIM_W-1:0];
					CFG_DIFF_ROW:  dr_gain = cfg_wdata;
					CFG_DIFF_COL:  dc_gain = cfg_wdata;
					CFG_ADV_ROW:   ar_gain = cfg_wdata;
					CFG_ADV_COL:   ac_gain = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_item(in_data);
		end
		pending = cell_q.size();
	end

endmodule

// ===== tb/sv/upwind_advection_diffusion_stencil_tb.sv =====
module upwind_advection_diffusion_stencil_tb;
	import uads_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [GAIN_W-1:0] cfg_wdata;
	int errors, pending;
	int idle_pct, stall_pct;
	logic in_acc;
	int quiet_cycles;
	int items_sent;

	upwind_advection_diffusion_stencil u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	upwind_advection_diffusion_stencil_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) in_acc <= in_valid && in_ready;

	always @(negedge clk) out_ready = ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_mode(int m);
		case (m % 4)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 69; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 69; end
			default: begin idle_pct = 14; stall_pct = 14; end
		endcase
	endtask

	task automatic push_cell(logic [31:0] u, logic [31:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data.u_old = u;
		in_data.v_old = v;
		do @(negedge clk); while (!in_acc);
		items_sent++;
	endtask

	task automatic drain;
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] a, logic [GAIN_W-1:0] d);
		cfg_we = 1'b1;
		cfg_addr = a;
		cfg_wdata = d;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic int unsigned eff_dim(logic [DIM_W-1:0] d);
		if (d < 3) return 3;
		if (d > 256) return 256;
		return d;
	endfunction

	function automatic logic [31:0] velocity(logic [31:0] base);
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return 32'h7FFFFFFF;
			2: return 32'h80000000;
			3: return 32'h0;
			4: return base + $urandom_range(0, 1 << 22) - (1 << 21);
			5: return $urandom_range(0, 1 << 25) - (1 << 24);
			default: return base + $urandom_range(0, 1 << 18) - (1 << 17);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] gain_pick();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(0, 1 << 23);
		endcase
	endfunction

	task automatic run_grid(logic [DIM_W-1:0] nr, logic [DIM_W-1:0] nc, bit new_gains);
		int unsigned r, c;
		logic [31:0] bu, bv;
		drain;
		write_reg(CFG_GRID_ROWS, nr);
		write_reg(CFG_GRID_COLS, nc);
		if (new_gains) begin
			write_reg(CFG_DIFF_ROW, gain_pick());
			write_reg(CFG_DIFF_COL, gain_pick());
			write_reg(CFG_ADV_ROW, gain_pick());
			write_reg(CFG_ADV_COL, gain_pick());
		end
		bu = $urandom_range(0, 1 << 26) - (1 << 25);
		bv = $urandom_range(0, 1 << 26) - (1 << 25);
		for (r = 0; r < eff_dim(nr); r++)
			for (c = 0; c < eff_dim(nc); c++)
				push_cell(velocity(bu), velocity(bv));
	endtask

	initial begin
		logic [31:0] du [0:8];
		logic [31:0] dv [0:8];
		int k, m;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		items_sent = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		du = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF,
			32'h1, 32'h80000000, 32'h01000000, 32'hFF000000};
		dv = '{32'h80000000, 32'h7FFFFFFF, 32'h1, 32'h0, 32'h80000000,
			32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFF000000, 32'h01000000};
		write_reg(CFG_GRID_ROWS, 9'd0);
		write_reg(CFG_GRID_COLS, 9'd1);
		write_reg(CFG_DIFF_ROW, '1);
		write_reg(CFG_DIFF_COL, '1);
		write_reg(CFG_ADV_ROW, '1);
		write_reg(CFG_ADV_COL, '1);
		write_reg(3'd6, '0);
		write_reg(3'd7, '0);
		for (k = 0; k < 9; k++) push_cell(du[k], dv[k]);
		drain;
		write_reg(CFG_GRID_ROWS, 9'd2);
		write_reg(CFG_GRID_COLS, 9'd3);
		write_reg(CFG_DIFF_ROW, '0);
		write_reg(CFG_DIFF_COL, '0);
		write_reg(CFG_ADV_ROW, 31'h01000000);
		write_reg(CFG_ADV_COL, 31'h00800000);
		for (k = 0; k < 9; k++) push_cell(dv[8 - k], (k == 4) ? 32'h0 : du[k]);

		m = 0;
		while (items_sent < 205) begin
			set_mode(m);
			run_grid($urandom_range(3, 7), $urandom_range(3, 7), 1'b1);
			m++;
		end
		drain;
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/uads_pkg.sv
rtl/core/uads_ram.sv
rtl/core/uads_mul.sv
rtl/core/uads_ctrl.sv
rtl/core/uads_dp.sv
rtl/core/upwind_advection_diffusion_stencil.sv
tb/sv/upwind_advection_diffusion_stencil_chk.sv
tb/sv/upwind_advection_diffusion_stencil_tb.sv
